// File: sv/drmf_pkg.sv
// shared types and constants for the depth reprojection motion field block
package drmf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COORD_W = 12;
    localparam int COEF_W  = 32;
    localparam int DEPTH_W = 32;
    localparam int S_W     = COEF_W + COORD_W + 3;
    localparam int HI_W    = S_W - FRAC_BITS;
    localparam int M1_W    = HI_W + DEPTH_W;
    localparam int M2_W    = FRAC_BITS + DEPTH_W;
    localparam int SUM_W   = 66;
    localparam int P_W     = 63;
    localparam int MAG_W   = 62;
    localparam int QB      = 34;
    localparam int SH      = QB - FRAC_BITS;
    localparam int MOT_W   = QB + 2;

    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = 6;
    localparam int IDX_W    = 3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QB-1:0]    nlow;
        logic [QB-1:0]    q;
    } t_lane;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               neg_x;
        logic               neg_y;
        logic               zero;
        logic               sat;
        logic               ovf_x;
        logic               ovf_y;
        logic [MAG_W-1:0]   den;
        t_lane              lx;
        t_lane              ly;
    } t_div;

endpackage

// File: sv/drmf_div_stage.sv
// one quotient bit of the two dividers, registered
module drmf_div_stage
    import drmf_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_item,
    output t_div o_item
);

    t_div r_item;
    t_div n_item;

    function automatic t_lane div_step(t_lane l, logic [MAG_W-1:0] den);
        logic [MAG_W:0] t;
        logic [MAG_W:0] dif;
        logic           ge;
        t_lane          r;
        t = {l.rem, l.nlow[QB-1]};
        dif = t - {1'b0, den};
        ge = (t >= {1'b0, den});
        r.rem = ge ? dif[MAG_W-1:0] : t[MAG_W-1:0];
        r.nlow = {l.nlow[QB-2:0], 1'b0};
        r.q = {l.q[QB-2:0], ge};
        return r;
    endfunction

    always_comb begin
        n_item = i_item;
        n_item.lx = div_step(i_item.lx, i_item.den);
        n_item.ly = div_step(i_item.ly, i_item.den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// File: sv/depth_reprojection_motion_field.sv
// depth reprojection motion field top level: projection, divide and output stages
// pipeline: 8 projection stages, 34 divider stages with one quotient bit each
// and 1 output register
// throughput: one item per cycle; the whole pipeline holds while the output waits
// reset: synchronous active-low reset clears all valid bits and the six
// coefficient registers to zero
module depth_reprojection_motion_field
    import drmf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [COORD_W-1:0]        i_pixel_col,
    input  logic [COORD_W-1:0]        i_pixel_row,
    input  logic [DEPTH_W-1:0]        i_depth,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [31:0]        o_motion_x,
    output logic signed [31:0]        o_motion_y,
    output logic [1:0]                o_status,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output logic                      pready
);

    localparam logic signed [SUM_W-1:0] P_LIM = SUM_W'(67'sd1 <<< 61);

    logic [63:0] r_cfg [NUM_REGS];
    logic [IDX_W-1:0] w_idx;
    logic en;

    assign w_idx = paddr[ADDR_W-1:3];
    assign pready = 1'b1;
    assign prdata = (32'(w_idx) < NUM_REGS) ? r_cfg[w_idx] : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= 64'd0;
            end
        end else if (psel && penable && pwrite && (32'(w_idx) < NUM_REGS)) begin
            r_cfg[w_idx] <= pwdata;
        end
    end

    assign en = !o_valid || i_ready;
    assign o_ready = en;

    // valid bits of the projection, divider and output stages
    logic [7:0] r_v;
    logic [QB-1:0] r_dv;
    logic r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            r_dv <= '0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_v <= {r_v[6:0], i_valid};
            r_dv <= {r_dv[QB-2:0], r_v[7]};
            r_o_valid <= r_dv[QB-1];
        end
    end

    assign o_valid = r_o_valid;

    // coordinates and depth travel along the projection stages
    logic [COORD_W-1:0] r_col [7];
    logic [COORD_W-1:0] r_row [7];
    logic [DEPTH_W-1:0] r_d [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col[0] <= (32'(i_pixel_col) >= MAX_WIDTH) ? COORD_W'(MAX_WIDTH - 1)
                                                         : i_pixel_col;
            r_row[0] <= (32'(i_pixel_row) >= MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT - 1)
                                                          : i_pixel_row;
            r_d[0] <= i_depth;
            for (int k = 1; k < 7; k++) begin
                r_col[k] <= r_col[k-1];
                r_row[k] <= r_row[k-1];
            end
            for (int k = 1; k < 4; k++) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    logic signed [COEF_W+COORD_W:0] r_px [3];
    logic signed [COEF_W+COORD_W:0] r_py [3];
    logic signed [S_W-1:0]          r_s  [3];
    logic [HI_W-1:0]                r_mag [3];
    logic [FRAC_BITS-1:0]           r_lo [3];
    logic                           r_neg_d [3];
    logic [M1_W-1:0]                r_m1 [3];
    logic [M2_W-1:0]                r_m2 [3];
    logic                           r_neg_e [3];
    logic signed [P_W-1:0]          r_p [3];
    logic                           r_sat_f;
    logic signed [SUM_W-1:0]        w_sum [3];
    logic signed [P_W-1:0]          w_p [3];
    logic [2:0]                     w_psat;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = (r_neg_e[k] ? -$signed({3'b0, r_m1[k]}) : $signed({3'b0, r_m1[k]}))
                     + $signed(SUM_W'(r_m2[k] >> FRAC_BITS))
                     + SUM_W'($signed(r_cfg[2*k+1][63:32]));
            w_psat[k] = 1'b1;
            if (r_m1[k] > M1_W'(P_LIM)) begin
                w_p[k] = r_neg_e[k] ? P_W'(-P_LIM) : P_W'(P_LIM);
            end else if (w_sum[k] > P_LIM) begin
                w_p[k] = P_W'(P_LIM);
            end else if (w_sum[k] < -P_LIM) begin
                w_p[k] = P_W'(-P_LIM);
            end else begin
                w_p[k] = P_W'(w_sum[k]);
                w_psat[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_px[k] <= $signed(r_cfg[2*k][31:0]) * $signed({1'b0, r_col[0]});
                r_py[k] <= $signed(r_cfg[2*k][63:32]) * $signed({1'b0, r_row[0]});
                r_s[k] <= S_W'(r_px[k]) + S_W'(r_py[k])
                        + S_W'($signed(r_cfg[2*k+1][31:0]));
                r_neg_d[k] <= r_s[k][S_W-1];
                r_mag[k] <= r_s[k][S_W-1] ? HI_W'(-r_s[k][S_W-1:FRAC_BITS])
                                          : r_s[k][S_W-1:FRAC_BITS];
                r_lo[k] <= r_s[k][FRAC_BITS-1:0];
                r_m1[k] <= M1_W'(r_mag[k] * r_d[3]);
                r_m2[k] <= M2_W'(r_lo[k] * r_d[3]);
                r_neg_e[k] <= r_neg_d[k];
                r_p[k] <= w_p[k];
            end
            r_sat_f <= |w_psat;
        end
    end

    // magnitudes and signs of the projected point
    logic [MAG_W-1:0] r_abs [3];
    logic [2:0]       r_sgn;
    logic             r_zero_g;
    logic             r_sat_g;
    t_div             r_h;
    t_div             w_div [QB+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_sgn[k] <= r_p[k][P_W-1];
                r_abs[k] <= r_p[k][P_W-1] ? MAG_W'(-r_p[k]) : MAG_W'(r_p[k]);
            end
            r_zero_g <= (r_p[2] == '0);
            r_sat_g <= r_sat_f;
            r_h.col <= r_col[6];
            r_h.row <= r_row[6];
            r_h.neg_x <= r_sgn[0] ^ r_sgn[2];
            r_h.neg_y <= r_sgn[1] ^ r_sgn[2];
            r_h.zero <= r_zero_g;
            r_h.sat <= r_sat_g;
            r_h.ovf_x <= {{SH{1'b0}}, r_abs[0]} >= {r_abs[2], {SH{1'b0}}};
            r_h.ovf_y <= {{SH{1'b0}}, r_abs[1]} >= {r_abs[2], {SH{1'b0}}};
            r_h.den <= r_abs[2];
            r_h.lx.rem <= r_abs[0] >> SH;
            r_h.lx.nlow <= {r_abs[0][SH-1:0], {FRAC_BITS{1'b0}}};
            r_h.lx.q <= '0;
            r_h.ly.rem <= r_abs[1] >> SH;
            r_h.ly.nlow <= {r_abs[1][SH-1:0], {FRAC_BITS{1'b0}}};
            r_h.ly.q <= '0;
        end
    end

    assign w_div[0] = r_h;

    genvar gi;
    generate
        for (gi = 0; gi < QB; gi++) begin : g_div
            drmf_div_stage u_stage (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_item (w_div[gi]),
                .o_item (w_div[gi+1])
            );
        end
    endgenerate

    // sign, subtract the pixel position and saturate
    t_div w_f;
    logic signed [MOT_W-1:0] w_x2, w_y2, w_dx, w_dy;
    logic signed [31:0] w_mx, w_my;
    logic w_sx, w_sy;

    assign w_f = w_div[QB];

    always_comb begin
        w_x2 = w_f.neg_x ? -$signed({2'b0, w_f.lx.q}) : $signed({2'b0, w_f.lx.q});
        w_y2 = w_f.neg_y ? -$signed({2'b0, w_f.ly.q}) : $signed({2'b0, w_f.ly.q});
        w_dx = w_x2 - $signed(MOT_W'({w_f.col, {FRAC_BITS{1'b0}}}));
        w_dy = w_y2 - $signed(MOT_W'({w_f.row, {FRAC_BITS{1'b0}}}));
        w_sx = 1'b1;
        w_sy = 1'b1;
        if (w_f.ovf_x) begin
            w_mx = w_f.neg_x ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (w_dx > MOT_W'(32'sh7fff_ffff)) begin
            w_mx = 32'sh7fff_ffff;
        end else if (w_dx < MOT_W'(32'sh8000_0000)) begin
            w_mx = 32'sh8000_0000;
        end else begin
            w_mx = 32'(w_dx);
            w_sx = 1'b0;
        end
        if (w_f.ovf_y) begin
            w_my = w_f.neg_y ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (w_dy > MOT_W'(32'sh7fff_ffff)) begin
            w_my = 32'sh7fff_ffff;
        end else if (w_dy < MOT_W'(32'sh8000_0000)) begin
            w_my = 32'sh8000_0000;
        end else begin
            w_my = 32'(w_dy);
            w_sy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (w_f.zero) begin
                o_motion_x <= '0;
                o_motion_y <= '0;
                o_status <= ST_ZERO;
            end else begin
                o_motion_x <= w_mx;
                o_motion_y <= w_my;
                o_status <= (w_f.sat || w_sx || w_sy) ? ST_SAT : ST_OK;
            end
        end
    end

endmodule

// File: bench/testbench.sv
// testbench for the depth reprojection motion field block: directed and random pixels
`timescale 1ns / 100ps

module testbench;
    import drmf_pkg::*;

    typedef enum int {
        REG_ROW0_MUL = 0,
        REG_ROW0_ADD = 1,
        REG_ROW1_MUL = 2,
        REG_ROW1_ADD = 3,
        REG_ROW2_MUL = 4,
        REG_ROW2_ADD = 5,
        REG_UNUSED   = 6
    } t_reg_idx;

    typedef struct {
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic [1:0]         st;
    } t_motion;

    localparam int    LATENCY = 43;
    localparam logic [63:0] P_LIM = 64'h1 << 61;
    localparam logic [63:0] Q_MAX = 64'h1 << 38;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [COORD_W-1:0] i_pixel_col;
    logic [COORD_W-1:0] i_pixel_row;
    logic [DEPTH_W-1:0] i_depth;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_motion_x;
    logic signed [31:0] o_motion_y;
    logic [1:0]         o_status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;

    logic [63:0] coef_regs [NUM_REGS];
    t_motion     motion_q [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    int          mismatches;

    depth_reprojection_motion_field DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint signed sext32(logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic longint signed project_row(logic [63:0] mul, logic [63:0] add,
                                                  longint signed x, longint signed y,
                                                  logic [63:0] d, inout bit sat);
        longint signed s, hi, p, c;
        logic [63:0]   lo, mag, prod;
        s = sext32(mul[31:0]) * x + sext32(mul[63:32]) * y + sext32(add[31:0]);
        c = sext32(add[63:32]);
        hi = s >>> FRAC_BITS;
        lo = s & 64'hFFFF;
        mag = (hi < 0) ? -hi : hi;
        if (d != 0 && mag > P_LIM / d) begin
            sat = 1'b1;
            return (hi < 0) ? -longint'(P_LIM) : longint'(P_LIM);
        end
        prod = d * mag;
        p = prod;
        if (hi < 0)
            p = -p;
        prod = (d * lo) >> FRAC_BITS;
        p = p + longint'(prod) + c;
        if (p > longint'(P_LIM)) begin
            sat = 1'b1;
            p = P_LIM;
        end
        if (p < -longint'(P_LIM)) begin
            sat = 1'b1;
            p = -longint'(P_LIM);
        end
        return p;
    endfunction

    function automatic longint signed fixed_quotient(longint signed n, longint signed dv);
        logic [63:0] un, ud, q, r;
        un = (n < 0) ? -n : n;
        ud = (dv < 0) ? -dv : dv;
        q = un / ud;
        r = un % ud;
        if (q > Q_MAX)
            q = Q_MAX;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ud) begin
                r = r - ud;
                q = q | 64'd1;
            end
        end
        return ((n < 0) != (dv < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [31:0] clamp32(longint signed v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_motion predict_motion(logic [11:0] col, logic [11:0] row,
                                               logic [31:0] depth);
        t_motion       m;
        bit            sat;
        longint signed x, y, p0, p1, p2;
        sat = 1'b0;
        x = col;
        y = row;
        p0 = project_row(coef_regs[REG_ROW0_MUL], coef_regs[REG_ROW0_ADD], x, y, depth, sat);
        p1 = project_row(coef_regs[REG_ROW1_MUL], coef_regs[REG_ROW1_ADD], x, y, depth, sat);
        p2 = project_row(coef_regs[REG_ROW2_MUL], coef_regs[REG_ROW2_ADD], x, y, depth, sat);
        if (p2 == 0) begin
            m.mx = '0;
            m.my = '0;
            m.st = ST_ZERO;
            return m;
        end
        m.mx = clamp32(fixed_quotient(p0, p2) - (x <<< FRAC_BITS), sat);
        m.my = clamp32(fixed_quotient(p1, p2) - (y <<< FRAC_BITS), sat);
        m.st = sat ? ST_SAT : ST_OK;
        return m;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [63:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_W'(8 * int'(idx));
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (int'(idx) < NUM_REGS)
            coef_regs[idx] = val;
    endtask

    task automatic write_matrix(logic [31:0] h [9], logic [31:0] c [3]);
        for (int i = 0; i < 3; i++) begin
            write_reg(t_reg_idx'(2 * i), {h[3*i+1], h[3*i]});
            write_reg(t_reg_idx'(2 * i + 1), {c[i], h[3*i+2]});
        end
    endtask

    task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [31:0] depth);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_pixel_col = col;
        i_pixel_row = row;
        i_depth = depth;
        do
            @(posedge i_clk);
        while (!o_ready);
        motion_q.push_back(predict_motion(col, row, depth));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (motion_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(9, 0))
            0: return 32'h0;
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            3: return $urandom;
            default: return 32'($urandom_range(8 * 65536, 0)) - 32'(4 * 65536);
        endcase
    endfunction

    function automatic logic [31:0] pick_depth();
        case ($urandom_range(7, 0))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return $urandom;
            default: return $urandom_range(64 * 65536, 1);
        endcase
    endfunction

    function automatic logic [11:0] pick_coord();
        case ($urandom_range(5, 0))
            0: return 12'd0;
            1: return 12'd4095;
            default: return 12'($urandom);
        endcase
    endfunction

    // mostly plausible camera setups, with random extremes mixed in
    task automatic load_random_matrix();
        logic [31:0] h [9];
        logic [31:0] c [3];
        bit          plausible;
        plausible = $urandom_range(3, 0) != 0;
        for (int i = 0; i < 9; i++)
            h[i] = pick_coef();
        for (int i = 0; i < 3; i++)
            c[i] = pick_coef();
        if (plausible) begin
            h[0] = 32'h10000 + 32'($urandom_range(8192, 0)) - 32'd4096;
            h[4] = 32'h10000 + 32'($urandom_range(8192, 0)) - 32'd4096;
            h[6] = 32'($urandom_range(64, 0)) - 32'd32;
            h[7] = 32'($urandom_range(64, 0)) - 32'd32;
            h[8] = 32'h10000 + 32'($urandom_range(16384, 0));
        end
        write_matrix(h, c);
    endtask

    task automatic test_reset_config();
        send_pixel(12'd0, 12'd0, 32'h0);
        send_pixel(12'd4095, 12'd4095, 32'hFFFFFFFF);
        send_pixel(12'd123, 12'd456, 32'h10000);
        wait_drained();
    endtask

    task automatic test_directed();
        logic [31:0] h [9];
        logic [31:0] c [3];
        h = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
        c = '{0, 0, 0};
        write_matrix(h, c);
        write_reg(REG_UNUSED, 64'hFFFFFFFF_FFFFFFFF);
        send_pixel(12'd0, 12'd0, 32'h10000);
        send_pixel(12'd4095, 12'd4095, 32'hFFFFFFFF);
        send_pixel(12'd4095, 12'd0, 32'h0);
        send_pixel(12'd0, 12'd4095, 32'h00018000);
        wait_drained();
        // translation and shear so motion is nonzero
        h = '{32'h11000, 32'h00800, 32'h20000, 32'hFFFFF000, 32'hF000, 32'hFFFD0000,
              32'h10, 32'hFFFFFFF0, 32'h10000};
        c = '{32'h00050000, 32'hFFFB0000, 32'h00008000};
        write_matrix(h, c);
        send_pixel(12'd17, 12'd900, 32'h00030000);
        send_pixel(12'd4095, 12'd4095, 32'h7FFFFFFF);
        send_pixel(12'd2048, 12'd1, 32'h1);
        wait_drained();
        // denominator driven to one lsb: huge quotient and output saturation
        h = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h80000000, 0, 0, 0};
        c = '{32'h7FFFFFFF, 32'h80000000, 32'h1};
        write_matrix(h, c);
        send_pixel(12'd4095, 12'd4095, 32'hFFFFFFFF);
        send_pixel(12'd0, 12'd0, 32'h0);
        send_pixel(12'd1, 12'd1, 32'h10000);
        wait_drained();
        // extreme coefficients on every row, including the denominator
        h = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
        c = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000};
        write_matrix(h, c);
        send_pixel(12'd4095, 12'd4095, 32'hFFFFFFFF);
        send_pixel(12'd2000, 12'd3000, 32'h80000000);
        wait_drained();
    endtask

    task automatic test_random(int sidle, int rstall);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        for (int k = 0; k < 5; k++) begin
            load_random_matrix();
            repeat (60)
                send_pixel(pick_coord(), pick_coord(), pick_depth());
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_random_matrix();
        hold_off_cycles = 300;
        repeat (100)
            send_pixel(pick_coord(), pick_coord(), pick_depth());
        wait_drained();
        repeat (20)
            send_pixel(pick_coord(), pick_coord(), pick_depth());
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_ready = 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            i_ready = $urandom_range(99, 0) >= recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        t_motion m;
        if (i_rst_n && o_valid && i_ready) begin
            if (motion_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: x=%h y=%h status=%0d",
                             o_motion_x, o_motion_y, o_status);
            end else begin
                m = motion_q.pop_front();
                if (m.mx !== o_motion_x || m.my !== o_motion_y || m.st !== o_status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%h y=%h st=%0d got x=%h y=%h st=%0d",
                                 m.mx, m.my, m.st, o_motion_x, o_motion_y, o_status);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_pixel_col = '0;
        i_pixel_row = '0;
        i_depth = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        mismatches = 0;
        for (int i = 0; i < NUM_REGS; i++)
            coef_regs[i] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_config();
        test_directed();
        test_random(0, 0);
        test_random(80, 0);
        test_random(0, 80);
        test_random(6, 6);
        test_backpressure();

        repeat (LATENCY + 20) @(posedge i_clk);
        if (motion_q.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
